FILE: sv/tbpr_pkg.sv
// shared types and constants of the tiled background pixel renderer
package tbpr_pkg;

    // field widths of one input item and one result item
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned ADDR_W   = 15;
    localparam int unsigned WDATA_W  = 16;
    localparam int unsigned COORD_W  = 8;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned RGBA_W   = 32;

    // configuration register fields
    localparam int unsigned MAP_BYTES_W  = 12;
    localparam int unsigned TILE_BYTES_W = 16;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 16;

    // palette geometry
    localparam int unsigned PAL_AW    = 8;
    localparam int unsigned PAL_DEPTH = 256;
    localparam int unsigned COLOR_W   = 15;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // request codes on the input tuser
    localparam logic [REQ_W-1:0] REQ_MAP_WR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TILE_WR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PAL_WR  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RENDER  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_BYTES = 1'd1;

    // map entry layout
    localparam int unsigned TILE_NUM_W = 10;
    localparam int unsigned HFLIP_BIT  = 10;
    localparam int unsigned VFLIP_BIT  = 11;

    // work kinds after classification
    typedef enum logic [2:0] {
        KIND_NOP     = 3'd0,
        KIND_MAP_WR  = 3'd1,
        KIND_TILE_WR = 3'd2,
        KIND_PAL_WR  = 3'd3,
        KIND_RENDER  = 3'd4
    } kind_t;

    // one classified item in the queue
    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [WDATA_W-1:0]  data;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
    } item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [MAP_BYTES_W-1:0]  map_bytes;
        logic [TILE_BYTES_W-1:0] tile_bytes;
    } cfg_t;

endpackage

FILE: sv/tiled_background_pixel_renderer.sv
// A render transfer shows its pixel on m_tvalid after the map, tile and palette reads
// and the output load. Throughput: store writes retire one per cycle while no render
// is in progress; a render holds the back end until its pixel is loaded into the output.
// Reset: synchronous, active low; clears queue, sequencer, output valid,
// configuration and palette valid bits (unwritten palette entries read as zero).
module tiled_background_pixel_renderer #(
    parameter int unsigned MAP_ENTRIES      = 1024,
    parameter int unsigned TILE_STORE_BYTES = 32768
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // write_addr[14:0], write_data[30:15], pixel_x[38:31], pixel_y[46:39], zero[47]
    input  logic [tbpr_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [tbpr_pkg::REQ_W-1:0]      s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_rgba[31:0]
    output logic [tbpr_pkg::RGBA_W-1:0]     m_tdata,
    // opaque[0]
    output logic                            m_tuser,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbpr_pkg::CFG_DATA_W-1:0] cfg_data
);

    tbpr_pkg::cfg_t  cfg_reg;
    tbpr_pkg::item_t front_item;
    tbpr_pkg::item_t back_item;
    logic            q_push, q_space, q_avail, q_pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tbpr_pkg::CFG_MAP_BYTES: begin
                    cfg_reg.map_bytes <= cfg_data[tbpr_pkg::MAP_BYTES_W-1:0];
                end
                tbpr_pkg::CFG_TILE_BYTES: begin
                    cfg_reg.tile_bytes <= cfg_data;
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    tbpr_front #(
        .MAP_ENTRIES      (MAP_ENTRIES),
        .TILE_STORE_BYTES (TILE_STORE_BYTES)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_space  (q_space),
        .q_item   (front_item)
    );

    tbpr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .space     (q_space),
        .avail     (q_avail),
        .pop       (q_pop),
        .pop_item  (back_item)
    );

    tbpr_back #(
        .MAP_ENTRIES      (MAP_ENTRIES),
        .TILE_STORE_BYTES (TILE_STORE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_avail  (q_avail),
        .q_pop    (q_pop),
        .q_item   (back_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sv/tbpr_front.sv
// front end: unpacks input transfers and classifies them into work kinds
module tbpr_front #(
    parameter int unsigned MAP_ENTRIES      = 1024,
    parameter int unsigned TILE_STORE_BYTES = 32768
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tbpr_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [tbpr_pkg::REQ_W-1:0]    s_tuser,
    output logic                          q_push,
    input  logic                          q_space,
    output tbpr_pkg::item_t               q_item
);

    localparam logic [tbpr_pkg::ADDR_W:0] MAP_LIMIT  = (tbpr_pkg::ADDR_W+1)'(MAP_ENTRIES);
    localparam logic [tbpr_pkg::ADDR_W:0] TILE_LIMIT =
        (tbpr_pkg::ADDR_W+1)'(TILE_STORE_BYTES);

    logic [tbpr_pkg::ADDR_W-1:0] addr;

    assign addr = s_tdata[14:0];

    // handshake follows queue space
    assign s_tready = q_space;
    assign q_push   = s_tvalid && q_space;

    always_comb begin
        // field unpacking
        q_item.addr = addr;
        q_item.data = s_tdata[30:15];
        q_item.x    = s_tdata[38:31];
        q_item.y    = s_tdata[46:39];

        // classify, dropping writes that fall outside their store
        q_item.kind = tbpr_pkg::KIND_NOP;
        case (s_tuser)
            tbpr_pkg::REQ_MAP_WR: begin
                if ({1'b0, addr} < MAP_LIMIT) q_item.kind = tbpr_pkg::KIND_MAP_WR;
            end
            tbpr_pkg::REQ_TILE_WR: begin
                if ({1'b0, addr} < TILE_LIMIT) q_item.kind = tbpr_pkg::KIND_TILE_WR;
            end
            tbpr_pkg::REQ_PAL_WR: begin
                if (addr[tbpr_pkg::ADDR_W-1:tbpr_pkg::PAL_AW] == '0)
                    q_item.kind = tbpr_pkg::KIND_PAL_WR;
            end
            tbpr_pkg::REQ_RENDER: begin
                q_item.kind = tbpr_pkg::KIND_RENDER;
            end
            default: begin
                q_item.kind = tbpr_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

FILE: sv/tbpr_queue.sv
// short queue of classified items between front and back
module tbpr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tbpr_pkg::item_t push_item,
    output logic            space,
    output logic            avail,
    input  logic            pop,
    output tbpr_pkg::item_t pop_item
);

    localparam int unsigned QAW = $clog2(tbpr_pkg::QUEUE_DEPTH);
    localparam logic [QAW-1:0] LAST_SLOT = QAW'(tbpr_pkg::QUEUE_DEPTH - 1);
    localparam logic [QAW:0]   FULL      = (QAW+1)'(tbpr_pkg::QUEUE_DEPTH);

    tbpr_pkg::item_t slot_reg [tbpr_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;
    logic            do_push, do_pop;

    assign space    = (count_reg != FULL);
    assign avail    = (count_reg != '0);
    assign do_push  = push && space;
    assign do_pop   = pop && avail;
    assign pop_item = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/tbpr_back.sv
// back end: store writes and the three-read render sequence with output register
module tbpr_back #(
    parameter int unsigned MAP_ENTRIES      = 1024,
    parameter int unsigned TILE_STORE_BYTES = 32768
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tbpr_pkg::cfg_t              cfg,
    input  logic                        q_avail,
    output logic                        q_pop,
    input  tbpr_pkg::item_t             q_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tbpr_pkg::RGBA_W-1:0] m_tdata,
    output logic                        m_tuser
);

    localparam int unsigned MAP_AW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int unsigned TILE_AW = (TILE_STORE_BYTES > 1) ? $clog2(TILE_STORE_BYTES) : 1;
    localparam logic [tbpr_pkg::TILE_NUM_W:0] MAP_LIMIT =
        (tbpr_pkg::TILE_NUM_W+1)'(MAP_ENTRIES);
    localparam logic [tbpr_pkg::ADDR_W:0] TILE_LIMIT =
        (tbpr_pkg::ADDR_W+1)'(TILE_STORE_BYTES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAP  = 5'b00010,
        S_TILE = 5'b00100,
        S_PAL  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // stores
    logic [15:0]                     map_mem  [MAP_ENTRIES];
    logic [7:0]                      tile_mem [TILE_STORE_BYTES];
    logic [tbpr_pkg::COLOR_W-1:0]    pal_mem  [tbpr_pkg::PAL_DEPTH];
    logic [tbpr_pkg::PAL_DEPTH-1:0]  pal_valid_reg;

    // current render coordinate
    logic [tbpr_pkg::COORD_W-1:0] cur_x_reg, cur_y_reg;

    // read stage registers
    logic [15:0]                  map_rd_reg;
    logic                         map_ok_reg;
    logic [7:0]                   tile_rd_reg;
    logic                         tile_hit_reg;
    logic                         nib_hi_reg;
    logic [3:0]                   bank_reg;
    logic [tbpr_pkg::COLOR_W-1:0] pal_rd_reg;
    logic                         pal_vld_reg;
    logic                         draw_reg;

    // output register
    logic                        m_tvalid_reg;
    logic [tbpr_pkg::RGBA_W-1:0] m_tdata_reg;
    logic                        m_tuser_reg;

    logic                                 out_free;
    logic                                 take;
    logic [tbpr_pkg::TILE_NUM_W-1:0]      map_idx;
    logic [11:0]                          map_end;
    logic                                 map_ok;
    logic [MAP_AW-1:0]                    map_raddr;
    logic [15:0]                          entry;
    logic [2:0]                           in_x, in_y;
    logic [tbpr_pkg::ADDR_W-1:0]          tile_addr;
    logic                                 tile_hit;
    logic [TILE_AW-1:0]                   tile_raddr;
    logic [3:0]                           ci;
    logic [tbpr_pkg::PAL_AW-1:0]          pal_raddr;
    logic [tbpr_pkg::COLOR_W-1:0]         color;
    logic [tbpr_pkg::RGBA_W-1:0]          rgba;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE);
    assign take     = q_pop && q_avail;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (take && q_item.kind == tbpr_pkg::KIND_RENDER) state_next = S_MAP;
            end
            S_MAP:  state_next = S_TILE;
            S_TILE: state_next = S_PAL;
            S_PAL:  state_next = S_OUT;
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // latch coordinate of a render item
    always_ff @(posedge aclk) begin
        if (take && q_item.kind == tbpr_pkg::KIND_RENDER) begin
            cur_x_reg <= q_item.x;
            cur_y_reg <= q_item.y;
        end
    end

    // map entry address and length check
    always_comb begin
        map_idx   = {cur_y_reg[7:3], cur_x_reg[7:3]};
        map_end   = 12'({map_idx, 1'b0}) + 12'd2;
        map_ok    = ({1'b0, map_idx} < MAP_LIMIT) && (map_end <= cfg.map_bytes);
        map_raddr = map_ok ? map_idx[MAP_AW-1:0] : '0;
    end

    // map store
    always_ff @(posedge aclk) begin
        if (take && q_item.kind == tbpr_pkg::KIND_MAP_WR) begin
            map_mem[q_item.addr[MAP_AW-1:0]] <= q_item.data;
        end
        map_rd_reg <= map_mem[map_raddr];
        map_ok_reg <= map_ok;
    end

    // entry decode, flips and tile byte address
    always_comb begin
        entry = map_ok_reg ? map_rd_reg : 16'h0000;
        in_x  = entry[tbpr_pkg::HFLIP_BIT] ? ~cur_x_reg[2:0] : cur_x_reg[2:0];
        in_y  = entry[tbpr_pkg::VFLIP_BIT] ? ~cur_y_reg[2:0] : cur_y_reg[2:0];
        tile_addr = {entry[tbpr_pkg::TILE_NUM_W-1:0], in_y, in_x[2:1]};
        tile_hit  = ({1'b0, entry[tbpr_pkg::TILE_NUM_W-1:0]} < cfg.tile_bytes[15:5])
                    && ({1'b0, tile_addr} < TILE_LIMIT);
        tile_raddr = tile_hit ? tile_addr[TILE_AW-1:0] : '0;
    end

    // tile store
    always_ff @(posedge aclk) begin
        if (take && q_item.kind == tbpr_pkg::KIND_TILE_WR) begin
            tile_mem[q_item.addr[TILE_AW-1:0]] <= q_item.data[7:0];
        end
        tile_rd_reg  <= tile_mem[tile_raddr];
        tile_hit_reg <= tile_hit;
        nib_hi_reg   <= in_x[0];
        bank_reg     <= entry[15:12];
    end

    // color index pick
    always_comb begin
        ci        = nib_hi_reg ? tile_rd_reg[7:4] : tile_rd_reg[3:0];
        pal_raddr = {bank_reg, ci};
    end

    // palette store, entries read as zero until written
    always_ff @(posedge aclk) begin
        if (take && q_item.kind == tbpr_pkg::KIND_PAL_WR) begin
            pal_mem[q_item.addr[tbpr_pkg::PAL_AW-1:0]] <= q_item.data[tbpr_pkg::COLOR_W-1:0];
        end
        pal_rd_reg <= pal_mem[pal_raddr];
        draw_reg   <= tile_hit_reg && (ci != 4'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_valid_reg <= '0;
            pal_vld_reg   <= 1'b0;
        end else begin
            if (take && q_item.kind == tbpr_pkg::KIND_PAL_WR) begin
                pal_valid_reg[q_item.addr[tbpr_pkg::PAL_AW-1:0]] <= 1'b1;
            end
            pal_vld_reg <= pal_valid_reg[pal_raddr];
        end
    end

    // bgr555 widened to abgr8888
    always_comb begin
        color = pal_vld_reg ? pal_rd_reg : '0;
        rgba  = {8'hFF, color[14:10], 3'b000, color[9:5], 3'b000, color[4:0], 3'b000};
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= draw_reg ? rgba : '0;
            m_tuser_reg <= draw_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
